### rtl/core/salcp_pkg.sv
// Package for the suffix array / LCP builder.
// Transaction structs, opcodes, status codes and controller command/status types.
`timescale 1ns / 1ps
package salcp_pkg;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [4:0] symbol;
        logic       last_symbol;
        logic [9:0] rank_index;
    } req_t;

    typedef struct packed {
        logic [9:0] suffix_start;
        logic [9:0] common_prefix;
        logic [1:0] status;
    } rsp_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OPC_NOP     = 4'd0,
        OPC_INIT    = 4'd1,  // rank=text, second=identity
        OPC_CLR     = 4'd2,  // clear bucket counts
        OPC_HIST    = 4'd3,  // count ranks
        OPC_PSUM    = 4'd4,  // prefix sum over buckets
        OPC_SCAT    = 4'd5,  // scatter into suffix order
        OPC_SK_TAIL = 4'd6,  // second key: tail positions
        OPC_SK_BODY = 4'd7,  // second key: shifted suffixes
        OPC_COPY    = 4'd8,  // old rank = rank
        OPC_RERANK  = 4'd9,  // new ranks
        OPC_LCP     = 4'd10, // Kasai
        OPC_NEXTJ   = 4'd11  // double the step
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   start;   // pulse: begin the phase
    } dp_cmd_t;

    typedef struct packed {
        logic done;      // phase finished this cycle
        logic sorted;    // all ranks distinct after last rerank
    } dp_sts_t;
endpackage

### rtl/core/salcp_datapath.sv
// Datapath of the suffix array / LCP builder: stores and phase engines.
// Uses salcp_pkg. Each phase sweeps memories in short read-then-write sub-steps,
// with at most one phase-engine memory read per cycle.
`timescale 1ns / 1ps
module salcp_datapath #(
    parameter int MAX_LEN = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  salcp_pkg::dp_cmd_t  cmd,
    output salcp_pkg::dp_sts_t  sts,
    input  logic                ld_we,
    input  logic [$clog2(MAX_LEN)-1:0] ld_addr,
    input  logic [4:0]          ld_sym,
    input  logic [$clog2(MAX_LEN+1)-1:0] len,
    input  logic                rd_en,
    input  logic [9:0]          rd_idx,
    output logic [9:0]          rd_sa,
    output logic [9:0]          rd_lcp
);
    import salcp_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN+1);
    localparam int KSPAN = ((MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET) + 1;
    localparam int KW = $clog2(KSPAN);
    localparam int SW = $clog2(ALPHABET+1);

    // memories
    logic [SW-1:0] text_mem [MAX_LEN];
    logic [AW-1:0] sa_mem   [MAX_LEN];
    logic [KW-1:0] rank_mem [MAX_LEN];
    logic [KW-1:0] old_mem  [MAX_LEN];
    logic [AW-1:0] sk_mem   [MAX_LEN];
    logic [LW-1:0] cnt_mem  [KSPAN];
    logic [AW-1:0] lcp_mem  [MAX_LEN];

    // sweep state
    logic          act_reg;
    dp_op_t        op_reg;
    logic [LW:0]   i_reg;      // main index
    logic [2:0]    sub_reg;    // sub-step
    logic [LW:0]   j_reg;      // doubling step
    logic [LW:0]   p_reg;      // write pointer / rank counter
    logic [LW:0]   h_reg;      // Kasai h
    logic [KW-1:0] ta_reg, tb_reg, tc_reg, td_reg;
    logic [AW-1:0] a_reg, b_reg, k_reg;
    logic [LW-1:0] acc_reg;
    logic [LW-1:0] cv_reg;     // bucket count read back
    logic [KW-1:0] maxkey;
    logic          done_reg;

    assign maxkey = (LW'(len) > LW'(ALPHABET)) ? KW'(len) : KW'(ALPHABET);
    assign sts.done   = done_reg;
    assign sts.sorted = (p_reg >= (LW+1)'(len));

    logic [LW:0] lenx;
    assign lenx = (LW+1)'(len);

    // clamp symbol
    logic [SW-1:0] sym_c;
    always_comb
    begin
        if (ld_sym == 5'd0) sym_c = SW'(1);
        else if (32'(ld_sym) > ALPHABET) sym_c = SW'(ALPHABET);
        else sym_c = SW'(ld_sym);
    end

    // read port of result
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_sa  <= 10'(sa_mem[rd_idx[AW-1:0]]);
            rd_lcp <= 10'(lcp_mem[rd_idx[AW-1:0]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_we) text_mem[ld_addr] <= sym_c;
    end

    // phase engine: each element takes a sequence of sub-steps, at most one memory read each
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OPC_NOP;
            i_reg    <= '0;
            sub_reg  <= '0;
            j_reg    <= '0;
            p_reg    <= '0;
            h_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                act_reg <= 1'b1;
                op_reg  <= cmd.op;
                sub_reg <= '0;
                acc_reg <= '0;
                unique case (cmd.op)
                    OPC_SCAT:    i_reg <= lenx;
                    OPC_PSUM:    i_reg <= (LW+1)'(1);
                    OPC_SK_TAIL:
                    begin
                        i_reg <= (lenx > j_reg) ? lenx - j_reg : '0;
                        p_reg <= '0;
                    end
                    OPC_RERANK:  begin i_reg <= '0; p_reg <= (LW+1)'(1); end
                    OPC_LCP:     begin i_reg <= '0; h_reg <= '0; end
                    OPC_INIT:    begin i_reg <= '0; j_reg <= (LW+1)'(1); end
                    default:     i_reg <= '0;
                endcase
            end
            else if (act_reg)
            begin
                unique case (op_reg)
                    OPC_INIT:
                    begin
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            ta_reg <= KW'(text_mem[i_reg[AW-1:0]]); sub_reg <= 3'd1;
                        end else begin
                            rank_mem[i_reg[AW-1:0]] <= ta_reg;
                            sk_mem[i_reg[AW-1:0]]   <= i_reg[AW-1:0];
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_CLR:
                    begin
                        if (i_reg >= (LW+1)'(KSPAN)) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else begin cnt_mem[i_reg[KW-1:0]] <= '0; i_reg <= i_reg + 1'b1; end
                    end
                    OPC_HIST:
                    begin
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            ta_reg <= rank_mem[i_reg[AW-1:0]]; sub_reg <= 3'd1;
                        end else if (sub_reg == 3'd1) begin
                            acc_reg <= cnt_mem[ta_reg]; sub_reg <= 3'd2;
                        end else begin
                            cnt_mem[ta_reg] <= acc_reg + 1'b1;
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_PSUM:
                    begin
                        if (sub_reg == 3'd0) begin
                            acc_reg <= cnt_mem['0]; sub_reg <= 3'd1;
                        end else if (i_reg > (LW+1)'(maxkey)) begin
                            act_reg <= 1'b0; done_reg <= 1'b1;
                        end else if (sub_reg == 3'd1) begin
                            cv_reg <= cnt_mem[i_reg[KW-1:0]]; sub_reg <= 3'd2;
                        end else begin
                            cnt_mem[i_reg[KW-1:0]] <= acc_reg + cv_reg;
                            acc_reg <= acc_reg + cv_reg;
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd1;
                        end
                    end
                    OPC_SCAT:
                    begin
                        if (i_reg == '0) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            a_reg <= sk_mem[AW'(i_reg - 1'b1)]; sub_reg <= 3'd1;
                        end else if (sub_reg == 3'd1) begin
                            ta_reg <= rank_mem[a_reg]; sub_reg <= 3'd2;
                        end else if (sub_reg == 3'd2) begin
                            acc_reg <= cnt_mem[ta_reg]; sub_reg <= 3'd3;
                        end else begin
                            cnt_mem[ta_reg] <= acc_reg - 1'b1;
                            sa_mem[AW'(acc_reg - 1'b1)] <= a_reg;
                            i_reg <= i_reg - 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_SK_TAIL:
                    begin
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else begin
                            sk_mem[p_reg[AW-1:0]] <= i_reg[AW-1:0];
                            p_reg <= p_reg + 1'b1; i_reg <= i_reg + 1'b1;
                        end
                    end
                    OPC_SK_BODY:
                    begin
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            a_reg <= sa_mem[i_reg[AW-1:0]]; sub_reg <= 3'd1;
                        end else begin
                            if ((LW+1)'(a_reg) >= j_reg) begin
                                sk_mem[p_reg[AW-1:0]] <= AW'((LW+1)'(a_reg) - j_reg);
                                p_reg <= p_reg + 1'b1;
                            end
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_COPY:
                    begin
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            ta_reg <= rank_mem[i_reg[AW-1:0]]; sub_reg <= 3'd1;
                        end else begin
                            old_mem[i_reg[AW-1:0]] <= ta_reg;
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_RERANK:
                    begin
                        // sub 0: a=sa[i]; 1: ta=old[a]; 2: tb=old[a+j];
                        // 3: compare with previous (tc,td), write rank
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            a_reg <= sa_mem[i_reg[AW-1:0]]; sub_reg <= 3'd1;
                        end else if (sub_reg == 3'd1) begin
                            ta_reg <= old_mem[a_reg]; sub_reg <= 3'd2;
                        end else if (sub_reg == 3'd2) begin
                            if ((LW+1)'(a_reg) + j_reg < lenx)
                                tb_reg <= old_mem[AW'((LW+1)'(a_reg) + j_reg)];
                            else
                                tb_reg <= '0;
                            sub_reg <= 3'd3;
                        end else begin
                            if (i_reg == '0) begin
                                rank_mem[a_reg] <= KW'(1);
                            end else if (ta_reg == tc_reg && tb_reg == td_reg) begin
                                rank_mem[a_reg] <= KW'(p_reg);
                            end else begin
                                rank_mem[a_reg] <= KW'(p_reg + 1'b1);
                                p_reg <= p_reg + 1'b1;
                            end
                            tc_reg <= ta_reg; td_reg <= tb_reg;
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    OPC_NEXTJ:
                    begin
                        j_reg <= {j_reg[LW-1:0], 1'b0};
                        act_reg <= 1'b0; done_reg <= 1'b1;
                    end
                    OPC_LCP:
                    begin
                        // sub 0: r=rank[i]; 1: k=sa[r-2]; 2: bounds; 3, 4: read chars;
                        // 5: compare; 6: write
                        if (i_reg >= lenx) begin act_reg <= 1'b0; done_reg <= 1'b1; end
                        else if (sub_reg == 3'd0) begin
                            ta_reg <= rank_mem[i_reg[AW-1:0]];
                            if (h_reg != '0) h_reg <= h_reg - 1'b1;
                            sub_reg <= 3'd1;
                        end else if (sub_reg == 3'd1) begin
                            if (ta_reg <= KW'(1)) begin
                                h_reg <= '0;
                                lcp_mem['0] <= '0;
                                i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                            end else begin
                                k_reg <= sa_mem[AW'(ta_reg - KW'(2))]; sub_reg <= 3'd2;
                            end
                        end else if (sub_reg == 3'd2) begin
                            if (i_reg + h_reg < lenx && (LW+1)'(k_reg) + h_reg < lenx)
                            begin
                                b_reg   <= AW'(i_reg + h_reg);
                                a_reg   <= AW'((LW+1)'(k_reg) + h_reg);
                                sub_reg <= 3'd3;
                            end else sub_reg <= 3'd6;
                        end else if (sub_reg == 3'd3) begin
                            tc_reg <= KW'(text_mem[b_reg]); sub_reg <= 3'd4;
                        end else if (sub_reg == 3'd4) begin
                            td_reg <= KW'(text_mem[a_reg]); sub_reg <= 3'd5;
                        end else if (sub_reg == 3'd5) begin
                            if (tc_reg == td_reg) begin
                                h_reg <= h_reg + 1'b1; sub_reg <= 3'd2;
                            end else sub_reg <= 3'd6;
                        end else begin
                            lcp_mem[AW'(ta_reg - KW'(1))] <= AW'(h_reg);
                            i_reg <= i_reg + 1'b1; sub_reg <= 3'd0;
                        end
                    end
                    default: begin act_reg <= 1'b0; done_reg <= 1'b1; end
                endcase
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd.start |=> act_reg)
        else $error("phase did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !act_reg)
        else $error("done while active");
    assert property (@(posedge clk) disable iff (!rst_n) act_reg |-> !cmd.start)
        else $error("start while phase active");
endmodule

### rtl/core/salcp_ctrl.sv
// Controller of the suffix array / LCP builder: sequences the build phases.
// Uses salcp_pkg; drives salcp_datapath through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps
module salcp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    output logic               busy,
    output logic               built,
    output salcp_pkg::dp_cmd_t cmd,
    input  salcp_pkg::dp_sts_t sts
);
    import salcp_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_INIT = 11'b00000000010,
        S_CLR  = 11'b00000000100,
        S_HIST = 11'b00000001000,
        S_PSUM = 11'b00000010000,
        S_SCAT = 11'b00000100000,
        S_TAIL = 11'b00001000000,
        S_BODY = 11'b00010000000,
        S_COPY = 11'b00100000000,
        S_RRNK = 11'b01000000000,
        S_LCP  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   first_reg, first_next;   // initial sort, before doubling
    logic   nextj_reg, nextj_next;   // doubling step pending
    logic   built_reg, built_next;

    assign busy  = (state_reg != S_IDLE);
    assign built = built_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            first_reg  <= 1'b0;
            nextj_reg  <= 1'b0;
            built_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            first_reg  <= first_next;
            nextj_reg  <= nextj_next;
            built_reg  <= built_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        first_next  = first_reg;
        nextj_next  = nextj_reg;
        built_next  = built_reg;
        cmd.start   = 1'b0;
        cmd.op      = OPC_NOP;
        unique case (state_reg)
            S_IDLE:  cmd.op = OPC_NOP;
            S_INIT:  cmd.op = OPC_INIT;
            S_CLR:   cmd.op = OPC_CLR;
            S_HIST:  cmd.op = OPC_HIST;
            S_PSUM:  cmd.op = OPC_PSUM;
            S_SCAT:  cmd.op = OPC_SCAT;
            S_TAIL:  cmd.op = OPC_SK_TAIL;
            S_BODY:  cmd.op = OPC_SK_BODY;
            S_COPY:  cmd.op = OPC_COPY;
            S_RRNK:  cmd.op = nextj_reg ? OPC_NEXTJ : OPC_RERANK;
            S_LCP:   cmd.op = OPC_LCP;
            default: cmd.op = OPC_NOP;
        endcase
        if (state_reg == S_IDLE)
        begin
            if (go)
            begin
                state_next  = S_INIT;
                issued_next = 1'b0;
                first_next  = 1'b1;
                built_next  = 1'b0;
            end
        end
        else if (!issued_reg)
        begin
            cmd.start   = 1'b1;
            issued_next = 1'b1;
        end
        else if (sts.done)
        begin
            issued_next = 1'b0;
            unique case (state_reg)
                S_INIT: state_next = S_CLR;
                S_CLR:  state_next = S_HIST;
                S_HIST: state_next = S_PSUM;
                S_PSUM: state_next = S_SCAT;
                S_SCAT:
                begin
                    if (first_reg) begin first_next = 1'b0; state_next = S_TAIL; end
                    else state_next = S_COPY;
                end
                S_TAIL: state_next = S_BODY;
                S_BODY: state_next = S_CLR;
                S_COPY: state_next = S_RRNK;
                S_RRNK:
                begin
                    if (nextj_reg) begin nextj_next = 1'b0; state_next = S_TAIL; end
                    else if (sts.sorted) state_next = S_LCP;
                    else nextj_next = 1'b1;
                end
                S_LCP:  begin state_next = S_IDLE; built_next = 1'b1; end
                default: state_next = S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && go |=> busy)
        else $error("build did not begin");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.start |=> !cmd.start)
        else $error("double phase start");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LCP) && sts.done && issued_reg |=> built_reg)
        else $error("built flag not set");
endmodule

### rtl/core/suffix_array_lcp_builder_top.sv
// Suffix array and LCP builder, top level: load/read front end.
// Depends on salcp_pkg, salcp_ctrl and salcp_datapath.
// Loads and reads: one per cycle while not busy; read results pass the p1/p2 registers, no stall.
// Final load starts a build of n letters: a first counting sort, then rounds of prefix doubling
// until all ranks are distinct (up to ceil(log2 n) rounds for n > 1), then Kasai for the LCP
// table (at most 2n matched letters in total).
// Reset is asynchronous active low: length, built and overflow flags cleared.
`timescale 1ns / 1ps
module suffix_array_lcp_builder_top #(
    parameter int MAX_LEN = 1024,
    parameter int ALPHABET = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  salcp_pkg::req_t   req,
    output logic              strobe,
    output salcp_pkg::rsp_t   rsp
);
    import salcp_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN+1);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ctrl_busy, built, go;
    logic [LW-1:0] len_reg, len_next;
    logic    ovf_reg, ovf_next;
    logic    go_reg;
    logic    accept;
    logic    ld_we;
    logic [LW-1:0] base_len;
    logic    rd_en, rd_ok;
    logic    p1_vld_reg, p1_ok_reg, p2_vld_reg;
    logic [1:0] p1_st_reg;
    logic [9:0] rd_sa, rd_lcp;
    logic    stale_reg;   // built data invalid once a new string loads

    assign busy   = ctrl_busy || go_reg;
    assign accept = start && !busy;

    // loads restart the string after a build
    always_comb
    begin
        base_len = (built && !stale_reg) ? '0 : len_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        ld_we    = 1'b0;
        if (accept && req.opcode == OP_LOAD)
        begin
            if (built && !stale_reg) ovf_next = 1'b0;
            len_next = base_len;
            if (base_len < LW'(MAX_LEN))
            begin
                ld_we    = 1'b1;
                len_next = base_len + 1'b1;
            end
            else ovf_next = 1'b1;
        end
    end
    assign go = accept && req.opcode == OP_LOAD && req.last_symbol && (len_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            go_reg     <= 1'b0;
            stale_reg  <= 1'b1;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            go_reg  <= go;
            if (go_reg) stale_reg <= 1'b0;
            else if (accept && req.opcode == OP_LOAD) stale_reg <= 1'b1;
            p1_vld_reg <= rd_en;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    assign rd_en = accept && req.opcode == OP_READ;
    assign rd_ok = built && !stale_reg &&
                   ((LW+1)'(req.rank_index) < (LW+1)'(len_reg));

    always_ff @(posedge clk)
    begin
        p1_ok_reg <= rd_ok;
        p1_st_reg <= !rd_ok ? ST_BAD : (ovf_reg ? ST_OVERFLOW : ST_OK);
        rsp.suffix_start  <= p1_ok_reg ? rd_sa  : '0;
        rsp.common_prefix <= p1_ok_reg ? rd_lcp : '0;
        rsp.status        <= p1_st_reg;
    end
    assign strobe = p2_vld_reg;

    salcp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .busy  (ctrl_busy),
        .built (built),
        .cmd   (cmd),
        .sts   (sts)
    );

    salcp_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .ld_we   (ld_we),
        .ld_addr (base_len[AW-1:0]),
        .ld_sym  (req.symbol),
        .len     (len_reg),
        .rd_en   (rd_en),
        .rd_idx  (req.rank_index),
        .rd_sa   (rd_sa),
        .rd_lcp  (rd_lcp)
    );

    assert property (@(posedge clk) disable iff (!rst_n) rd_en |=> ##1 strobe)
        else $error("read transaction lost");
    assert property (@(posedge clk) disable iff (!rst_n) go |=> busy)
        else $error("build not busy");
    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= LW'(MAX_LEN))
        else $error("length beyond capacity");
endmodule

### tb/salcp_checker.sv
// Checker for the suffix array / LCP builder: watches the command and result
// channels, predicts every read result and compares it. Depends on salcp_pkg.
`timescale 1ns / 1ps
module salcp_checker
    import salcp_pkg::*;
#(
    parameter int MAX_LEN = 1024,
    parameter int ALPHABET = 26
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic strobe,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);
    localparam int KEY_SPAN = ((MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET) + 1;

    // predicted state of the builder
    int txt [MAX_LEN];
    int sfx [MAX_LEN];
    int rnk [MAX_LEN];
    int sec [MAX_LEN];
    int lcp [MAX_LEN];
    int old_rnk [MAX_LEN];
    int cnt [KEY_SPAN];
    int text_len;
    bit built;
    bit overflowed;

    rsp_t expected_reads [$];

    // stable counting sort of sec by rnk into sfx
    function automatic void sort_by_rank(int n, int maxkey);
        int p;
        for (int i = 0; i < KEY_SPAN; i++) cnt[i] = 0;
        for (int i = 0; i < n; i++) cnt[rnk[i]]++;
        for (int i = 1; i <= maxkey; i++) cnt[i] += cnt[i - 1];
        for (int i = n; i > 0; i--)
        begin
            p = sec[i - 1];
            cnt[rnk[p]]--;
            sfx[cnt[rnk[p]]] = p;
        end
    endfunction

    // prefix doubling, then Kasai for the LCP table
    function automatic void build_suffix_table();
        int n, maxkey, p, h, j, r, k, a, b, ra, rb;
        n = text_len;
        maxkey = (n > ALPHABET) ? n : ALPHABET;
        for (int i = 0; i < n; i++)
        begin
            rnk[i] = txt[i];
            sec[i] = i;
        end
        sort_by_rank(n, maxkey);
        p = 0;
        j = 1;
        while (p < n)
        begin
            p = 0;
            for (int i = ((n > j) ? n - j : 0); i < n; i++) sec[p++] = i;
            for (int i = 0; i < n; i++)
                if (sfx[i] >= j) sec[p++] = sfx[i] - j;
            sort_by_rank(n, maxkey);
            old_rnk = rnk;
            p = 1;
            rnk[sfx[0]] = 1;
            for (int i = 1; i < n; i++)
            begin
                a = sfx[i];
                b = sfx[i - 1];
                ra = (a + j < n) ? old_rnk[a + j] : 0;
                rb = (b + j < n) ? old_rnk[b + j] : 0;
                if (!(old_rnk[a] == old_rnk[b] && ra == rb)) p++;
                rnk[a] = p;
            end
            j = j << 1;
        end
        h = 0;
        for (int i = 0; i < n; i++)
        begin
            r = rnk[i];
            if (h > 0) h--;
            if (r <= 1)
            begin
                h = 0;
                lcp[0] = 0;
            end
            else
            begin
                k = sfx[r - 2];
                while (i + h < n && k + h < n && txt[i + h] == txt[k + h]) h++;
                lcp[r - 1] = h;
            end
        end
        built = 1;
    endfunction

    // one accepted transaction: update state, queue the read result
    function automatic void predict(req_t t);
        int sym;
        int idx;
        rsp_t e;
        if (t.opcode == OP_LOAD)
        begin
            if (built)
            begin
                text_len = 0;
                built = 0;
                overflowed = 0;
            end
            sym = int'(t.symbol);
            if (sym < 1) sym = 1;
            if (sym > ALPHABET) sym = ALPHABET;
            if (text_len < MAX_LEN) txt[text_len++] = sym;
            else overflowed = 1;
            if (t.last_symbol && text_len > 0) build_suffix_table();
        end
        else
        begin
            idx = int'(t.rank_index);
            if (!built || idx >= text_len)
            begin
                e.suffix_start = '0;
                e.common_prefix = '0;
                e.status = ST_BAD;
            end
            else
            begin
                e.suffix_start = 10'(sfx[idx]);
                e.common_prefix = 10'(lcp[idx]);
                e.status = overflowed ? ST_OVERFLOW : ST_OK;
            end
            expected_reads.push_back(e);
        end
    endfunction

    // compare results first, then take the new transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            errors = 0;
            text_len = 0;
            built = 0;
            overflowed = 0;
            expected_reads.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (expected_reads.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result %p", $time, rsp);
                end
                else
                begin
                    rsp_t e;
                    e = expected_reads.pop_front();
                    if (rsp.suffix_start !== e.suffix_start ||
                        rsp.common_prefix !== e.common_prefix ||
                        rsp.status !== e.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] mismatch: expected %p got %p", $time, e, rsp);
                    end
                end
            end
            if (start && !busy) predict(req);
        end
        pending = expected_reads.size();
    end
endmodule

### tb/suffix_array_lcp_builder_top_tb.sv
// Testbench top for the suffix array / LCP builder: clock, reset, stimulus
// and verdict. Depends on salcp_pkg, the builder RTL and salcp_checker.
`timescale 1ns / 1ps
module suffix_array_lcp_builder_top_tb;
    import salcp_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int REQ_W = $bits(req_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic strobe;
    rsp_t rsp;
    int   errors;
    int   pending;
    int   cycles;
    int   sent;
    bit   no_gaps;

    suffix_array_lcp_builder_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .strobe(strobe), .rsp(rsp)
    );

    salcp_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .strobe(strobe), .rsp(rsp), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // drive one transaction from a falling edge until accepted
    task automatic send(logic op, logic [4:0] sym, logic last, logic [9:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            start = 0;
            req = req_t'(REQ_W'($urandom));
            @(negedge clk);
        end
        start = 1;
        req.opcode = op;
        req.symbol = sym;
        req.last_symbol = last;
        req.rank_index = idx;
        forever
        begin
            #0.5;
            if (!busy) break;
            @(negedge clk);
        end
        @(posedge clk);
        @(negedge clk);
        start = 0;
        sent++;
    endtask

    task automatic load_letter(int sym, bit last);
        send(OP_LOAD, sym[4:0], last, 10'($urandom));
    endtask

    task automatic read_entry(int idx);
        send(OP_READ, 5'($urandom), 1'($urandom), idx[9:0]);
    endtask

    // one string with letters from 1..span, last mark on the final letter
    task automatic load_string(int len, int span);
        for (int i = 0; i < len; i++)
            load_letter($urandom_range(1, span), i == len - 1);
    endtask

    initial
    begin
        int len, span, reads;
        start = 0;
        req = '0;
        rst_n = 0;
        sent = 0;
        no_gaps = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // read before any build
        read_entry(0);
        read_entry(1023);
        // banana, with out-of-range codes clamped
        load_letter(2, 0); load_letter(1, 0); load_letter(14, 0);
        load_letter(1, 0); load_letter(14, 0); load_letter(0, 1);
        for (int i = 0; i < 7; i++) read_entry(i);
        // single letter above the alphabet, then a read past the end
        load_letter(31, 1);
        read_entry(0);
        read_entry(1);
        // partial load clears the old build: a read is refused until the string completes
        load_letter(5, 0);
        read_entry(0);
        load_letter(5, 1);
        read_entry(1);

        // overflow: full length string, last mark lands on a dropped letter
        no_gaps = 1;
        for (int i = 0; i < 1026; i++) load_letter($urandom_range(0, 31), i == 1025);
        no_gaps = 0;
        for (int i = 1016; i < 1024; i++) read_entry(i);
        read_entry(0);
        read_entry(511);

        // random sessions: well formed strings then reads, with some noise
        while (sent < 1950)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 24);
            span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(1, 26);
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < len; i++)
                begin
                    load_letter($urandom_range(0, 31), i == len - 1);
                    if ($urandom_range(0, 7) == 0) read_entry($urandom_range(0, 1023));
                end
            end
            else
                load_string(len, span);
            reads = $urandom_range(1, len + 3);
            for (int i = 0; i < reads; i++)
                read_entry(($urandom_range(0, 4) != 0) ? $urandom_range(0, len - 1)
                                                        : $urandom_range(0, 1023));
        end

        // drain
        while (pending != 0 || busy) @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### suffix_array_lcp_builder_top.f
rtl/core/salcp_pkg.sv
rtl/core/salcp_datapath.sv
rtl/core/salcp_ctrl.sv
rtl/core/suffix_array_lcp_builder_top.sv
tb/salcp_checker.sv
tb/suffix_array_lcp_builder_top_tb.sv
